/* design/rnmpg_pkg.sv */
// Shared constants, codes and control types for the radius nearest match block.
`timescale 1ns / 1ps

package rnmpg_pkg;

    // Sizing
    localparam int MAX_TARGETS = 1024;
    localparam int COORD_BITS  = 24;
    localparam int IDX_W       = $clog2(MAX_TARGETS);
    localparam int CNT_W       = $clog2(MAX_TARGETS + 1);
    localparam int QNUM_W      = 10;
    localparam int FRAC_BITS   = 16;

    // Register field widths
    localparam int RADIUS_W = 23;
    localparam int COEF_W   = 18;
    localparam int OFFS_W   = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    // Squared distances: wide enough for two squares and the 100 m limit
    localparam int DIST_W = (2 * COORD_BITS + 1 > 46) ? 2 * COORD_BITS + 1 : 46;
    localparam logic [63:0] LIMIT_100M_SQ = 64'd42949672960000;

    // Plane accumulator: three products plus the shifted offset
    localparam int PROD_W = COEF_W + COORD_BITS;
    localparam int ACC_W  = (PROD_W + 3 > OFFS_W + FRAC_BITS + 2) ? PROD_W + 3
                                                                  : OFFS_W + FRAC_BITS + 2;

    // Item function codes
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd4;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic start;
        logic issue;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

/* design/rnmpg_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module rnmpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* design/rnmpg_ctrl.sv */
// Controller state machine: item acceptance, scan sequencing and result hand-off.
`timescale 1ns / 1ps

module rnmpg_ctrl
    import rnmpg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == FUNC_QUERY)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.clear  = accept && (func == FUNC_CLEAR);
                cmd.load   = accept && (func == FUNC_LOAD);
                cmd.start  = accept && (func == FUNC_QUERY);
            end
            ST_SCAN:
            begin
                cmd.issue = !status.scan_done;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* design/rnmpg_dp.sv */
// Datapath: target store, distance pipeline, best tracking, plane gap and result register.
`timescale 1ns / 1ps

module rnmpg_dp
    import rnmpg_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    output dp_status_t                   status,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] pz,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         matched,
    output logic [QNUM_W-1:0]            query_number,
    output logic [QNUM_W-1:0]            match_index,
    output logic signed [COORD_BITS-1:0] match_x,
    output logic signed [COORD_BITS-1:0] match_y,
    output logic signed [COORD_BITS-1:0] gap
);

    localparam int RND_W = ACC_W + 1;
    localparam int Q_W   = RND_W - FRAC_BITS;

    localparam logic [1:0] GAP_X    = 2'd0;
    localparam logic [1:0] GAP_Y    = 2'd1;
    localparam logic [1:0] GAP_Z    = 2'd2;
    localparam logic [1:0] GAP_IDLE = 2'd3;

    localparam logic signed [Q_W-1:0] GAP_MAX =
        {{(Q_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] GAP_MIN =
        {{(Q_W - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

    // Configuration registers
    logic [RADIUS_W-1:0]      radius_reg;
    logic signed [COEF_W-1:0] plane_a_reg;
    logic signed [COEF_W-1:0] plane_b_reg;
    logic signed [COEF_W-1:0] plane_c_reg;
    logic signed [OFFS_W-1:0] offset_reg;
    logic [2*RADIUS_W-1:0]    rsq_reg;

    // Counters and query point
    logic [CNT_W-1:0]             target_count_reg;
    logic [CNT_W-1:0]             scan_addr_reg;
    logic [QNUM_W-1:0]            qnum_reg;
    logic signed [COORD_BITS-1:0] qx_reg;
    logic signed [COORD_BITS-1:0] qy_reg;
    logic signed [COORD_BITS-1:0] qz_reg;

    // Target memory
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_addr;
    logic [2*COORD_BITS-1:0]   ram_rdata;
    logic signed [COORD_BITS-1:0] tx;
    logic signed [COORD_BITS-1:0] ty;

    // Distance pipeline
    logic                         s0_valid_reg;
    logic [IDX_W-1:0]             s0_idx_reg;
    logic                         s1_valid_reg;
    logic [IDX_W-1:0]             s1_idx_reg;
    logic [COORD_BITS-1:0]        s1_dx_reg;
    logic [COORD_BITS-1:0]        s1_dy_reg;
    logic [COORD_BITS-1:0]        s1_tx_reg;
    logic [COORD_BITS-1:0]        s1_ty_reg;
    logic                         s2_valid_reg;
    logic [IDX_W-1:0]             s2_idx_reg;
    logic [2*COORD_BITS-1:0]      s2_sqx_reg;
    logic [2*COORD_BITS-1:0]      s2_sqy_reg;
    logic [COORD_BITS-1:0]        s2_tx_reg;
    logic [COORD_BITS-1:0]        s2_ty_reg;
    logic signed [COORD_BITS:0]   diff_x;
    logic signed [COORD_BITS:0]   diff_y;
    logic signed [COORD_BITS:0]   neg_x;
    logic signed [COORD_BITS:0]   neg_y;
    logic [COORD_BITS-1:0]        abs_x;
    logic [COORD_BITS-1:0]        abs_y;
    logic [DIST_W-1:0]            dist_sum;

    // Best candidate
    logic                    found_reg;
    logic [DIST_W-1:0]       best_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [COORD_BITS-1:0]   best_x_reg;
    logic [COORD_BITS-1:0]   best_y_reg;
    logic                    hit;

    // Plane gap
    logic [1:0]                   gap_step_reg;
    logic                         prod_valid_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [ACC_W-1:0]      gap_acc_reg;
    logic signed [COEF_W-1:0]     coef_sel;
    logic signed [COORD_BITS-1:0] coord_sel;
    logic [RND_W-1:0]             gap_t;
    logic signed [Q_W-1:0]        gap_q;
    logic [COORD_BITS-1:0]        gap_sat;

    logic out_valid_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RADIUS_W'(65536);
            plane_a_reg <= '0;
            plane_b_reg <= '0;
            plane_c_reg <= COEF_W'(65536);
            offset_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RADIUS:  radius_reg  <= cfg_data[RADIUS_W-1:0];
                CFG_PLANE_A: plane_a_reg <= $signed(cfg_data[COEF_W-1:0]);
                CFG_PLANE_B: plane_b_reg <= $signed(cfg_data[COEF_W-1:0]);
                CFG_PLANE_C: plane_c_reg <= $signed(cfg_data[COEF_W-1:0]);
                CFG_OFFSET:  offset_reg  <= $signed(cfg_data[OFFS_W-1:0]);
                default:     radius_reg  <= radius_reg;
            endcase
        end
    end

    // Squared radius, kept current
    always_ff @(posedge clk)
    begin
        rsq_reg <= radius_reg * radius_reg;
    end

    // Target count, scan address and query counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_count_reg <= '0;
            scan_addr_reg    <= '0;
            qnum_reg         <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                target_count_reg <= '0;
                qnum_reg         <= '0;
            end
            else if (cmd.load && target_count_reg < CNT_W'(MAX_TARGETS))
            begin
                target_count_reg <= target_count_reg + 1'b1;
            end
            if (cmd.start)
            begin
                scan_addr_reg <= '0;
            end
            else if (cmd.issue)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                qnum_reg <= qnum_reg + 1'b1;
            end
        end
    end

    // Query point latch
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            qx_reg <= px;
            qy_reg <= py;
            qz_reg <= pz;
        end
    end

    // Target store: x in the upper half, y in the lower
    assign ram_we   = cmd.load && (target_count_reg < CNT_W'(MAX_TARGETS));
    assign ram_addr = cmd.issue ? scan_addr_reg[IDX_W-1:0] : target_count_reg[IDX_W-1:0];

    rnmpg_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_TARGETS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({px, py}),
        .rdata (ram_rdata)
    );

    assign tx = $signed(ram_rdata[2*COORD_BITS-1:COORD_BITS]);
    assign ty = $signed(ram_rdata[COORD_BITS-1:0]);

    // Absolute coordinate differences
    always_comb
    begin
        diff_x = $signed({qx_reg[COORD_BITS-1], qx_reg}) - $signed({tx[COORD_BITS-1], tx});
        diff_y = $signed({qy_reg[COORD_BITS-1], qy_reg}) - $signed({ty[COORD_BITS-1], ty});
        neg_x  = -diff_x;
        neg_y  = -diff_y;
        abs_x  = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
        abs_y  = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= cmd.issue;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Pipeline payload: read, difference, square
    always_ff @(posedge clk)
    begin
        s0_idx_reg <= scan_addr_reg[IDX_W-1:0];
        s1_idx_reg <= s0_idx_reg;
        s1_dx_reg  <= abs_x;
        s1_dy_reg  <= abs_y;
        s1_tx_reg  <= tx;
        s1_ty_reg  <= ty;
        s2_idx_reg <= s1_idx_reg;
        s2_sqx_reg <= s1_dx_reg * s1_dx_reg;
        s2_sqy_reg <= s1_dy_reg * s1_dy_reg;
        s2_tx_reg  <= s1_tx_reg;
        s2_ty_reg  <= s1_ty_reg;
    end

    // Strictly smaller keeps the first target at the minimum
    assign dist_sum = DIST_W'(s2_sqx_reg) + DIST_W'(s2_sqy_reg);
    assign hit      = s2_valid_reg && (dist_sum < best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            found_reg <= 1'b0;
        end
        else if (hit)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            best_reg     <= DIST_W'(LIMIT_100M_SQ);
            best_idx_reg <= '0;
        end
        else if (hit)
        begin
            best_reg     <= dist_sum;
            best_idx_reg <= s2_idx_reg;
            best_x_reg   <= s2_tx_reg;
            best_y_reg   <= s2_ty_reg;
        end
    end

    // Plane gap: one shared multiplier, one term per cycle
    always_comb
    begin
        case (gap_step_reg)
            GAP_X:
            begin
                coef_sel  = plane_a_reg;
                coord_sel = qx_reg;
            end
            GAP_Y:
            begin
                coef_sel  = plane_b_reg;
                coord_sel = qy_reg;
            end
            GAP_Z:
            begin
                coef_sel  = plane_c_reg;
                coord_sel = qz_reg;
            end
            default:
            begin
                coef_sel  = '0;
                coord_sel = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_step_reg   <= GAP_IDLE;
            prod_valid_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            gap_step_reg   <= GAP_X;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= (gap_step_reg != GAP_IDLE);
            if (gap_step_reg != GAP_IDLE)
            begin
                gap_step_reg <= gap_step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef_sel * coord_sel;
        if (cmd.start)
        begin
            gap_acc_reg <= ACC_W'($signed({offset_reg, {FRAC_BITS{1'b0}}}));
        end
        else if (prod_valid_reg)
        begin
            gap_acc_reg <= gap_acc_reg + ACC_W'(prod_reg);
        end
    end

    // Round half up, floor, saturate
    always_comb
    begin
        gap_t = {gap_acc_reg[ACC_W-1], gap_acc_reg}
              + {{(RND_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
        gap_q = $signed(gap_t[RND_W-1:FRAC_BITS]);
        if (gap_q > GAP_MAX)
        begin
            gap_sat = GAP_MAX[COORD_BITS-1:0];
        end
        else if (gap_q < GAP_MIN)
        begin
            gap_sat = GAP_MIN[COORD_BITS-1:0];
        end
        else
        begin
            gap_sat = gap_q[COORD_BITS-1:0];
        end
    end

    // Match only inside the radius as well as the 100 m bound
    function automatic logic hit_final();
        hit_final = found_reg && (best_reg < DIST_W'(rsq_reg));
    endfunction

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            matched      <= hit_final();
            query_number <= qnum_reg;
            match_index  <= hit_final() ? QNUM_W'(best_idx_reg) : '0;
            match_x      <= hit_final() ? $signed(best_x_reg) : '0;
            match_y      <= hit_final() ? $signed(best_y_reg) : '0;
            gap          <= $signed(gap_sat);
        end
    end

    assign out_valid = out_valid_reg;

    // Status
    assign status.scan_done = (scan_addr_reg == target_count_reg);
    assign status.pipe_busy = s0_valid_reg || s1_valid_reg || s2_valid_reg
                           || prod_valid_reg || (gap_step_reg != GAP_IDLE);
    assign status.out_free  = !out_valid_reg || out_ready;

endmodule

/* design/radius_nearest_match_plane_gap.sv */
// Top level: fixed-radius nearest target match with plane gap.
//
//   channel   direction  handshake             payload
//   in        in         in_valid / in_ready   func, px, py, pz
//   out       out        out_valid / out_ready matched, query_number, match_index,
//                                              match_x, match_y, gap
//   cfg       in         cfg_write             cfg_index, cfg_data
//
// Clear and load items are taken directly in the idle state. A query holds off the
// input until its result has been handed to the output register: the memory is read
// one entry per cycle through its single port, and a three-stage distance pipeline plus
// the result step follow.
// Reset empties the target set and zeroes the query counter; no memory clearing.
// A finished result waits in the output register; a new item is taken only once
// the pending query has handed its result to that register.
`timescale 1ns / 1ps

module radius_nearest_match_plane_gap
    import rnmpg_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] pz,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         matched,
    output logic [QNUM_W-1:0]            query_number,
    output logic [QNUM_W-1:0]            match_index,
    output logic signed [COORD_BITS-1:0] match_x,
    output logic signed [COORD_BITS-1:0] match_y,
    output logic signed [COORD_BITS-1:0] gap,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    rnmpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .status   (status),
        .cmd      (cmd)
    );

    rnmpg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .px           (px),
        .py           (py),
        .pz           (pz),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .matched      (matched),
        .query_number (query_number),
        .match_index  (match_index),
        .match_x      (match_x),
        .match_y      (match_y),
        .gap          (gap)
    );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the radius nearest match block with plane gap.
`timescale 1ns / 1ps

module testbench
    import rnmpg_pkg::*;
();

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_IDX_W'(CFG_OFFSET + 1);
    localparam int SETTLE_CYCLES = 40;
    localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
    localparam int ONE_M = 1 << FRAC_BITS;
    localparam int HUNDRED_M = 100 * ONE_M;

    // One input item as queued for the driver
    typedef struct {
        logic [1:0]                   func;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
        bit                           hold;   // wait for all results before sending
    } point_cmd_t;

    // One query result
    typedef struct {
        logic                         hit;
        logic [QNUM_W-1:0]            qnum;
        logic [QNUM_W-1:0]            idx;
        logic signed [COORD_BITS-1:0] tx;
        logic signed [COORD_BITS-1:0] ty;
        logic signed [COORD_BITS-1:0] gap;
    } match_t;

    logic                         clk;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [1:0]                   func = FUNC_CLEAR;
    logic signed [COORD_BITS-1:0] px = '0;
    logic signed [COORD_BITS-1:0] py = '0;
    logic signed [COORD_BITS-1:0] pz = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic                         matched;
    logic [QNUM_W-1:0]            query_number;
    logic [QNUM_W-1:0]            match_index;
    logic signed [COORD_BITS-1:0] match_x;
    logic signed [COORD_BITS-1:0] match_y;
    logic signed [COORD_BITS-1:0] gap;
    logic                         cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = CFG_RADIUS;
    logic [CFG_W-1:0]             cfg_data = '0;

    radius_nearest_match_plane_gap dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .px           (px),
        .py           (py),
        .pz           (pz),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .matched      (matched),
        .query_number (query_number),
        .match_index  (match_index),
        .match_x      (match_x),
        .match_y      (match_y),
        .gap          (gap),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Traffic shaping and bookkeeping
    int sender_idle_pct = 14;
    int receiver_idle_pct = 76;
    point_cmd_t pending_points[$];
    match_t expected_matches[$];
    int results_due = 0;      // queries accepted (driver only)
    int results_seen = 0;     // results checked (monitor only)
    int hits_seen = 0;
    int items_accepted = 0;
    int error_count = 0;
    int cfg_writes = 0;
    int points_planned = 0;
    int plan_x[$];            // targets the stimulus expects to be stored
    int plan_y[$];
    point_cmd_t next_cmd;
    match_t want;

    // Target set and register copies used for prediction
    logic signed [COORD_BITS-1:0] store_x[MAX_TARGETS];
    logic signed [COORD_BITS-1:0] store_y[MAX_TARGETS];
    int                           held_count = 0;
    logic [QNUM_W-1:0]            next_qnum = '0;
    logic [RADIUS_W-1:0]          radius_setting = RADIUS_W'(65536);
    logic signed [COEF_W-1:0]     norm_a = '0;
    logic signed [COEF_W-1:0]     norm_b = '0;
    logic signed [COEF_W-1:0]     norm_c = COEF_W'(65536);
    logic signed [OFFS_W-1:0]     offset_setting = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Nearest stored target within radius and 100 m, plus the rounded plane gap
    function automatic match_t search_targets(logic signed [COORD_BITS-1:0] qx,
                                              logic signed [COORD_BITS-1:0] qy,
                                              logic signed [COORD_BITS-1:0] qz);
        match_t r;
        longint best, d, dx, dy, limit_sq, acc, q;
        int best_idx;
        bit found;
        best = longint'(LIMIT_100M_SQ);
        best_idx = 0;
        found = 1'b0;
        limit_sq = longint'(radius_setting) * longint'(radius_setting);
        for (int i = 0; i < held_count; i++)
        begin
            dx = longint'(qx) - longint'(store_x[i]);
            dy = longint'(qy) - longint'(store_y[i]);
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            d = dx * dx + dy * dy;
            // strict compare keeps the first of equally near targets
            if (d < best)
            begin
                best = d;
                best_idx = i;
                found = 1'b1;
            end
        end
        r.hit = found && (best < limit_sq);
        r.qnum = next_qnum;
        r.idx = r.hit ? QNUM_W'(best_idx) : '0;
        r.tx = r.hit ? store_x[best_idx] : '0;
        r.ty = r.hit ? store_y[best_idx] : '0;
        // Q.32 sum, round half up to Q7.16, then clamp
        acc = longint'(norm_a) * longint'(qx) + longint'(norm_b) * longint'(qy)
            + longint'(norm_c) * longint'(qz) + (longint'(offset_setting) <<< FRAC_BITS);
        q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (q > longint'(COORD_MAX))
            q = COORD_MAX;
        if (q < longint'(COORD_MIN))
            q = COORD_MIN;
        r.gap = COORD_BITS'(q);
        return r;
    endfunction

    // Update the target set for one accepted item; queries queue their result
    function automatic void apply_point(logic [1:0] f, logic signed [COORD_BITS-1:0] x,
                                        logic signed [COORD_BITS-1:0] y,
                                        logic signed [COORD_BITS-1:0] z);
        match_t m;
        case (f)
            FUNC_CLEAR:
            begin
                held_count = 0;
                next_qnum = '0;
            end
            FUNC_LOAD:
            begin
                // loads into a full set are dropped
                if (held_count < MAX_TARGETS)
                begin
                    store_x[held_count] = x;
                    store_y[held_count] = y;
                    held_count++;
                end
            end
            FUNC_QUERY:
            begin
                m = search_targets(x, y, z);
                expected_matches = {expected_matches, m};
                next_qnum++;
                results_due++;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic signed [63:0] exp_val,
                                        logic signed [63:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            error_count++;
        end
    endfunction

    // Driver: present queued items, predict each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= FUNC_CLEAR;
            px <= '0;
            py <= '0;
            pz <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_point(func, px, py, pz);
                items_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_points.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct
                    && (!pending_points[0].hold || results_due == results_seen))
                begin
                    next_cmd = pending_points.pop_front();
                    in_valid <= 1'b1;
                    func <= next_cmd.func;
                    px <= next_cmd.px;
                    py <= next_cmd.py;
                    pz <= next_cmd.pz;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_matches.size() == 0)
                begin
                    $error("unexpected result: query_number %0d", query_number);
                    error_count++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    check_field("matched", want.hit, matched);
                    check_field("query_number", want.qnum, query_number);
                    check_field("match_index", want.idx, match_index);
                    check_field("match_x", want.tx, match_x);
                    check_field("match_y", want.ty, match_y);
                    check_field("gap", want.gap, gap);
                    if (want.hit)
                        hits_seen++;
                    results_seen <= results_seen + 1;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    function automatic int rand_coord();
        return int'($urandom_range(0, (1 << COORD_BITS) - 1)) + COORD_MIN;
    endfunction

    function automatic int jitter(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // Queue one item and track which targets it should leave stored
    task automatic push_point(logic [1:0] f, int x, int y, int z, bit hold = 1'b0);
        point_cmd_t c;
        c.func = f;
        c.px = COORD_BITS'(x);
        c.py = COORD_BITS'(y);
        c.pz = COORD_BITS'(z);
        c.hold = hold;
        pending_points = {pending_points, c};
        if (f == FUNC_CLEAR)
        begin
            plan_x.delete();
            plan_y.delete();
        end
        else if (f == FUNC_LOAD && plan_x.size() < MAX_TARGETS)
        begin
            plan_x = {plan_x, int'(c.px)};
            plan_y = {plan_y, int'(c.py)};
        end
        if (f != FUNC_UNUSED)
            points_planned++;
    endtask

    task automatic push_query(int x, int y, bit hold = 1'b0);
        push_point(FUNC_QUERY, x, y, rand_coord(), hold);
    endtask

    // Wait until the block is idle with nothing left to check
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_points.size() != 0 || in_valid || results_due != results_seen);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_RADIUS:  radius_setting = data[RADIUS_W-1:0];
            CFG_PLANE_A: norm_a = data[COEF_W-1:0];
            CFG_PLANE_B: norm_b = data[COEF_W-1:0];
            CFG_PLANE_C: norm_c = data[COEF_W-1:0];
            CFG_OFFSET:  offset_setting = data[OFFS_W-1:0];
            default:
            begin
            end
        endcase
        cfg_writes++;
        @(negedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_coef();
        logic [CFG_W-1:0] data;
        data = CFG_W'($urandom);    // bits above the coefficient are junk
        case ($urandom_range(0, 5))
            0: data[COEF_W-1:0] = {1'b0, {(COEF_W - 1){1'b1}}};
            1: data[COEF_W-1:0] = {1'b1, {(COEF_W - 1){1'b0}}};
            2: data[COEF_W-1:0] = '0;
            3: data[COEF_W-1:0] = COEF_W'(65536);
            default: ;
        endcase
        return data;
    endfunction

    // New random register setting, extremes included
    task automatic pick_setting();
        logic [CFG_W-1:0] data;
        case ($urandom_range(0, 7))
            0: data = '0;
            1: data = 24'd1;
            2: data = 24'h7FFFFF;
            3: data = CFG_W'(HUNDRED_M);
            7: data = CFG_W'($urandom);
            default: data = CFG_W'($urandom_range(1, 4 * ONE_M));
        endcase
        data[CFG_W-1] = 1'($urandom_range(0, 1));
        write_reg(CFG_RADIUS, data);
        write_reg(CFG_PLANE_A, pick_coef());
        write_reg(CFG_PLANE_B, pick_coef());
        write_reg(CFG_PLANE_C, pick_coef());
        case ($urandom_range(0, 4))
            0: data = 24'h7FFFFF;
            1: data = 24'h800000;
            2: data = '0;
            default: data = CFG_W'($urandom);
        endcase
        write_reg(CFG_OFFSET, data);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'(CFG_UNUSED_LO + $urandom_range(0, 2)), CFG_W'($urandom));
    endtask

    // One random sequence: mostly load a cluster and query near it, at times after a clear
    task automatic queue_sequence();
        int kind, n, spread, cx, cy, t, lim;
        bit hold;
        kind = $urandom_range(0, 99);
        if (kind < 6)
            push_point(FUNC_UNUSED, rand_coord(), rand_coord(), rand_coord());
        else if (kind < 12)
            push_point($urandom_range(0, 1) ? FUNC_LOAD : FUNC_QUERY,
                       rand_coord(), rand_coord(), rand_coord());
        else
        begin
            if (plan_x.size() > 48 || $urandom_range(0, 3) == 0)
                push_point(FUNC_CLEAR, rand_coord(), rand_coord(), rand_coord());
            case ($urandom_range(0, 3))
                0: spread = 256;
                1: spread = ONE_M;
                2: spread = 1 << 20;
                default: spread = COORD_MAX;
            endcase
            cx = rand_coord();
            cy = rand_coord();
            // now and then a large set
            n = (kind < 15) ? $urandom_range(100, 200) : $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
            begin
                if (plan_x.size() != 0 && $urandom_range(0, 5) == 0)
                begin
                    // duplicate gives a tie for nearest
                    t = $urandom_range(0, plan_x.size() - 1);
                    push_point(FUNC_LOAD, plan_x[t], plan_y[t], rand_coord());
                end
                else
                    push_point(FUNC_LOAD, cx + jitter(spread), cy + jitter(spread),
                               rand_coord());
            end
            hold = ($urandom_range(0, 39) == 0);
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
            begin
                if (plan_x.size() != 0 && $urandom_range(0, 2) != 0)
                begin
                    t = $urandom_range(0, plan_x.size() - 1);
                    lim = $urandom_range(0, int'(radius_setting));
                    push_query(plan_x[t] + jitter(lim), plan_y[t] + jitter(lim), hold);
                end
                else
                    push_query(cx + jitter(spread), cy + jitter(spread), hold);
                hold = 1'b0;
            end
        end
    endtask

    task automatic run_random(int n);
        int start;
        wait_drained();
        pick_setting();
        start = points_planned;
        while (points_planned - start < n)
            queue_sequence();
    endtask

    // Stimulus and end of run
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset register values; empty set, ties, exactly-at-radius
        push_point(FUNC_QUERY, COORD_MAX, COORD_MIN, COORD_MAX);
        push_point(FUNC_LOAD, 0, 0, 0);
        push_point(FUNC_LOAD, ONE_M - 1, 0, 0);
        push_point(FUNC_LOAD, -ONE_M, 0, 0);
        push_point(FUNC_LOAD, 0, 0, 0);
        push_point(FUNC_QUERY, 0, 0, COORD_MIN);
        push_point(FUNC_QUERY, 2 * ONE_M - 1, 0, 0);
        push_point(FUNC_QUERY, -(2 * ONE_M - 1), 0, 0);
        push_point(FUNC_UNUSED, -1, -1, -1, 1'b1);
        push_point(FUNC_CLEAR, 0, 0, 0);
        push_point(FUNC_QUERY, 0, 0, 0);
        wait_drained();

        // Widest radius, extreme plane; the 100 m bound and gap saturation
        write_reg(CFG_RADIUS, 24'hFFFFFF);
        write_reg(CFG_PLANE_A, {6'b101010, 18'h1FFFF});
        write_reg(CFG_PLANE_B, 24'h020000);
        write_reg(CFG_PLANE_C, 24'hFE0000);
        write_reg(CFG_OFFSET, 24'h7FFFFF);
        write_reg(CFG_UNUSED_LO, 24'h5A5A5A);
        push_point(FUNC_LOAD, 0, 0, 0);
        push_point(FUNC_QUERY, HUNDRED_M, 0, 0);
        push_point(FUNC_QUERY, HUNDRED_M - 1, 0, 0);
        push_point(FUNC_QUERY, COORD_MIN, COORD_MAX, COORD_MAX);
        wait_drained();

        // Zero radius; gap rounding around half a unit
        write_reg(CFG_RADIUS, 24'h800000);
        write_reg(CFG_PLANE_A, 24'h000001);
        write_reg(CFG_PLANE_B, 24'hFC0000);
        write_reg(CFG_PLANE_C, 24'h000000);
        write_reg(CFG_OFFSET, 24'h000000);
        push_point(FUNC_QUERY, 32768, 0, 0);
        push_point(FUNC_QUERY, 32767, 0, 0);
        push_point(FUNC_QUERY, -32768, 0, 0);
        push_point(FUNC_QUERY, -32769, 0, 0);
        push_point(FUNC_QUERY, 0, 0, 0);
        push_point(FUNC_LOAD, COORD_MAX, COORD_MAX, 0);
        push_point(FUNC_QUERY, COORD_MIN, COORD_MIN, 0);

        // Random traffic, slow receiver
        repeat (3) run_random(58);

        // Random traffic, slow sender
        wait_drained();
        sender_idle_pct = 76;
        receiver_idle_pct = 14;
        repeat (3) run_random(58);

        // Random traffic, no idling
        wait_drained();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        repeat (3) run_random(58);
        wait_drained();

        if (expected_matches.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_matches.size());
            error_count++;
        end
        $display("Run summary: %0d items accepted, %0d query results checked, %0d matched.",
                 items_accepted, results_seen, hits_seen);
        $display("Run summary: %0d register writes; directed corners, then random traffic.",
                 cfg_writes);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #50000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
